/* src/swm_pkg.sv */
`timescale 1ns / 1ps

package swm_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// operation codes
	localparam logic [2:0] MODE_PUSH = 3'd0;
	localparam logic [2:0] MODE_POP  = 3'd1;
	localparam logic [2:0] MODE_PEEK = 3'd2;
	localparam logic [2:0] MODE_MID  = 3'd3;
	localparam logic [2:0] MODE_DEL  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         status;
		logic [6:0]         occupancy;
	} rsp_t;

endpackage

/* src/swm_ram.sv */
`timescale 1ns / 1ps

// simple dual-port RAM, registered read
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/stack_with_middle_access_unit.sv */
`timescale 1ns / 1ps
// Path: push, unknown op and any op on an empty stack go straight to the response register
//   (via S_RESP while it is held); pop, peek and read middle first pass the registered RAM read.
// Throughput: one request per cycle for push while the response register is free; a read holds
//   off requests until answered; delete middle moves words down one by one via the RAM port pair.
// Reset: arst_n clears the word count and the response valid; the RAM is not cleared.

module stack_with_middle_access_unit
	import swm_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,   // RAM read data for the addressed word is on rd_data
		S_SHIFT,  // moving words above the middle down by one
		S_RESP    // result held until the response register frees up
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [2:0]      mode_q;
	logic [AW-1:0]   ptr_q;
	rsp_t            res_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;

	// RAM ports
	logic            we;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] rd_data;

	logic            full;
	logic            empty;
	logic            is_push;
	logic            is_read;
	logic            direct;
	logic            out_free;
	logic            rsp_set;
	logic [AW-1:0]   top_addr;
	logic [AW-1:0]   mid_addr;
	logic [CW:0]     ptr_ext;
	logic            more_load;
	logic            more_shift;
	rsp_t            idle_res;
	rsp_t            load_res;

	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);
	assign is_push  = (req.mode == MODE_PUSH);
	assign is_read  = (req.mode == MODE_POP) || (req.mode == MODE_PEEK) ||
	                  (req.mode == MODE_MID) || (req.mode == MODE_DEL);
	// ops that finish without touching the RAM read port
	assign direct   = !is_read || empty;
	assign out_free = !rsp_valid_q || rsp_ready;

	assign top_addr = AW'(count_q - CW'(1));
	assign mid_addr = AW'((count_q - CW'(1)) >> 1);

	// shared pointer compare: is there still a word at ptr+1 / ptr+2 to move?
	assign ptr_ext    = (CW + 1)'(ptr_q);
	assign more_load  = (ptr_ext + (CW + 1)'(1)) < {1'b0, count_q};
	assign more_shift = (ptr_ext + (CW + 1)'(2)) < {1'b0, count_q};

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// response register loads this cycle
	always_comb begin
		case (state_q)
			S_IDLE:  rsp_set = req_valid && direct && out_free;
			S_LOAD:  rsp_set = !((mode_q == MODE_DEL) && more_load) && out_free;
			S_SHIFT: rsp_set = !more_shift && out_free;
			S_RESP:  rsp_set = out_free;
			default: rsp_set = 1'b0;
		endcase
	end

	// RAM address and write control
	always_comb begin
		case (state_q)
			S_IDLE: begin
				raddr = ((req.mode == MODE_MID) || (req.mode == MODE_DEL)) ? mid_addr : top_addr;
			end
			S_LOAD:  raddr = ptr_q + AW'(1);
			S_SHIFT: raddr = ptr_q + AW'(2);
			default: raddr = top_addr;
		endcase
		if (state_q == S_SHIFT) begin
			we    = 1'b1;
			waddr = ptr_q;
			wdata = rd_data;
		end else begin
			we    = (state_q == S_IDLE) && req_valid && is_push && !full;
			waddr = AW'(count_q);
			wdata = DATA_WIDTH'(req.push_value);
		end
	end

	// result of ops that finish on acceptance
	always_comb begin
		idle_res.result_value = '0;
		idle_res.status       = ST_OK;
		idle_res.occupancy    = 7'(count_q);
		if (is_push) begin
			if (full) begin
				idle_res.status = ST_FULL;
			end else begin
				idle_res.occupancy = 7'({1'b0, count_q} + (CW + 1)'(1));
			end
		end else if (is_read) begin
			idle_res.result_value = '1;
			idle_res.status       = ST_EMPTY;
		end
	end

	// result of a RAM read; word sign-extended or cut to the 32-bit field
	always_comb begin
		load_res.result_value = 32'(signed'(rd_data));
		load_res.status       = ST_OK;
		load_res.occupancy    = (mode_q == MODE_DEL) ? 7'(count_q - CW'(1)) : 7'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q <= req.mode;
						ptr_q  <= mid_addr;
						if (direct) begin
							if (is_push && !full) begin
								count_q <= count_q + CW'(1);
							end
							if (out_free) begin
								rsp_q <= idle_res;
							end else begin
								res_q   <= idle_res;
								state_q <= S_RESP;
							end
						end else begin
							if (req.mode == MODE_POP) begin
								count_q <= count_q - CW'(1);
							end
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					res_q <= load_res;
					if ((mode_q == MODE_DEL) && more_load) begin
						state_q <= S_SHIFT;
					end else begin
						if (mode_q == MODE_DEL) begin
							count_q <= count_q - CW'(1);
						end
						if (out_free) begin
							rsp_q   <= load_res;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_SHIFT: begin
					if (more_shift) begin
						ptr_q <= ptr_q + AW'(1);
					end else begin
						count_q <= count_q - CW'(1);
						if (out_free) begin
							rsp_q   <= res_q;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	swm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// word count never runs past the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("word count beyond depth");

	// a refused push only ever happens on a full stack
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |-> (rsp.occupancy == 7'(DEPTH)))
		else $error("full status with room left");

	// empty answers carry -1 and an empty stack
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_EMPTY) |->
		(rsp.occupancy == 7'd0 && rsp.result_value == -32'sd1))
		else $error("malformed empty response");

	// shift pointer stays below the moved region
	a_shift_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> more_load)
		else $error("shift pointer out of range");

endmodule

/* tb/sv/tb_stack_with_middle_access_unit.sv */
`timescale 1ns / 1ps

// Self-checking bench for the bounded stack with middle access.
// A behavioural copy of the stack runs alongside the block: each request beat that the
// block takes is applied to it and the response it yields is queued. Every response beat
// is checked field by field against the oldest queued response.

module tb_stack_with_middle_access_unit;
	import swm_pkg::*;

	// Codes 5..7 are not operations; the block must answer them without touching the stack
	localparam logic [2:0] MODE_RSVD_LO  = 3'd5;
	localparam logic [2:0] MODE_RSVD_MID = 3'd6;
	localparam logic [2:0] MODE_RSVD_HI  = 3'd7;

	localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

	localparam int HOLD_CYCLES  = 300;     // long receiver stall, enough to back up the input
	localparam int TAIL_CYCLES  = 60;      // longer than the worst delete-middle time
	localparam int CYCLE_LIMIT  = 500000;  // watchdog bound on the whole run
	localparam int RANDOM_ITEMS = 1250;

	typedef enum {RX_STEADY, RX_COIN, RX_RARE_STALL, RX_EVERY_THIRD} rx_style_t;
	typedef enum {PH_FILL, PH_CHURN, PH_DRAIN} load_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	stack_with_middle_access_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Behavioural stack: words held bottom first, top at held_count-1
	// ------------------------------------------------------------------
	logic [31:0] held_words [DEPTH_DEF];
	int unsigned held_count = 0;

	// Coverage tallies for the closing summary
	int unsigned peak_count = 0;
	int unsigned refused_pushes = 0;
	int unsigned empty_reads = 0;
	int unsigned middle_deletes = 0;
	int unsigned items_sent = 0;
	int unsigned beats_checked = 0;

	rsp_t stack_expected [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	// Applies one operation to the behavioural stack and returns the response it should give
	function automatic rsp_t stack_predict(input req_t r);
		rsp_t o;
		int unsigned mid;
		o.result_value = '0;
		o.status = ST_OK;
		case (r.mode)
			MODE_PUSH: begin
				if (held_count >= DEPTH_DEF) begin
					o.status = ST_FULL;
					refused_pushes++;
				end else begin
					held_words[held_count] = r.push_value;
					held_count++;
				end
			end
			MODE_POP, MODE_PEEK, MODE_MID, MODE_DEL: begin
				if (held_count == 0) begin
					// nothing to read: -1 and the empty status, stack untouched
					o.result_value = WORD_ONES;
					o.status = ST_EMPTY;
					empty_reads++;
				end else if (r.mode == MODE_POP) begin
					held_count--;
					o.result_value = held_words[held_count];
				end else if (r.mode == MODE_PEEK) begin
					o.result_value = held_words[held_count - 1];
				end else begin
					// middle sits at (n-1)/2 from the bottom
					mid = (held_count - 1) / 2;
					o.result_value = held_words[mid];
					if (r.mode == MODE_DEL) begin
						for (int unsigned i = mid; i + 1 < held_count; i++)
							held_words[i] = held_words[i + 1];
						held_count--;
						middle_deletes++;
					end
				end
			end
			default: ;  // reserved codes: no change, zero word, ok status
		endcase
		if (held_count > peak_count)
			peak_count = held_count;
		o.occupancy = held_count[6:0];
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// ------------------------------------------------------------------
	// Response checker: one beat per rsp_valid && rsp_ready edge
	// ------------------------------------------------------------------
	rsp_t oldest_expected;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			beats_checked++;
			if (stack_expected.size() == 0) begin
				report_mismatch("response beat with nothing outstanding", rsp.result_value,
					'0);
			end else begin
				oldest_expected = stack_expected.pop_front();
				if (rsp.result_value !== oldest_expected.result_value)
					report_mismatch("result_value", rsp.result_value,
						oldest_expected.result_value);
				if (rsp.status !== oldest_expected.status)
					report_mismatch("status", 32'(rsp.status), 32'(oldest_expected.status));
				if (rsp.occupancy !== oldest_expected.occupancy)
					report_mismatch("occupancy", 32'(rsp.occupancy),
						32'(oldest_expected.occupancy));
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: rotates through stall styles; a long hold is asked for by bumping
	// hold_asked, and the stretch itself is counted here
	// ------------------------------------------------------------------
	int unsigned hold_asked = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	rx_style_t rx_style = RX_STEADY;
	int unsigned rx_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = HOLD_CYCLES - 1;
			rsp_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_style = rx_style_t'($urandom_range(RX_EVERY_THIRD, RX_STEADY));
				rx_left = $urandom_range(80, 16);
			end
			rx_left--;
			case (rx_style)
				RX_STEADY:      rsp_ready <= 1'b1;
				RX_COIN:        rsp_ready <= 1'($urandom_range(1, 0));
				RX_RARE_STALL:  rsp_ready <= ($urandom_range(9, 0) != 0);
				RX_EVERY_THIRD: rsp_ready <= (cycle_count % 3 == 0);
				default:        rsp_ready <= 1'b1;
			endcase
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
				stack_expected.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	int unsigned burst_left = 0;

	function automatic req_t make_req(input logic [2:0] mode, input logic [31:0] value);
		req_t r;
		r.mode = mode;
		r.push_value = value;
		return r;
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(15, 0))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return WORD_ONES;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	// Push share in percent; a few reserved codes mixed in as noise
	function automatic req_t random_req(input int unsigned push_pct);
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick < 3)
			return make_req(3'($urandom_range(MODE_RSVD_HI, MODE_RSVD_LO)), random_word());
		else if (pick < 3 + push_pct)
			return make_req(MODE_PUSH, random_word());
		else
			return make_req(3'($urandom_range(MODE_DEL, MODE_POP)), random_word());
	endfunction

	// Called at a clock edge; leaves valid high so back-to-back beats need no re-raise
	task automatic send_beat(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		stack_expected.push_back(stack_predict(r));
		items_sent++;
	endtask

	// One beat, then the burst/gap pacing
	task automatic offer(input req_t r);
		int unsigned gap;
		send_beat(r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(5, 0);
			// now and then a long gap-free run
			burst_left = ($urandom_range(3, 0) == 0) ? 40 : $urandom_range(10, 1);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and sit until every outstanding response is back
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (stack_expected.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every read on an empty stack, then the reserved codes
	task automatic test_empty_stack();
		offer(make_req(MODE_POP, random_word()));
		offer(make_req(MODE_PEEK, random_word()));
		offer(make_req(MODE_MID, random_word()));
		offer(make_req(MODE_DEL, random_word()));
		offer(make_req(MODE_RSVD_LO, WORD_ONES));
		offer(make_req(MODE_RSVD_MID, '0));
		offer(make_req(MODE_RSVD_HI, WORD_MAX));
	endtask

	// Extreme words through every operation, odd and even counts for the middle
	task automatic test_word_extremes();
		offer(make_req(MODE_PUSH, WORD_MAX));
		offer(make_req(MODE_PUSH, WORD_MIN));
		offer(make_req(MODE_PUSH, WORD_ONES));
		offer(make_req(MODE_PUSH, '0));
		offer(make_req(MODE_PUSH, 32'h5555_5555));
		offer(make_req(MODE_PEEK, '0));
		offer(make_req(MODE_MID, '0));
		offer(make_req(MODE_DEL, '0));    // removes the all-ones word
		offer(make_req(MODE_MID, '0));    // even count: lower middle
		offer(make_req(MODE_DEL, '0));
		offer(make_req(MODE_MID, '0));
		offer(make_req(MODE_POP, '0));
		offer(make_req(MODE_RSVD_MID, 32'hAAAA_AAAA));
		offer(make_req(MODE_POP, '0));
		offer(make_req(MODE_PEEK, '0));
	endtask

	// Receiver holds off for a long stretch while pushes keep coming, so the block backs up
	task automatic test_backpressure_hold();
		hold_asked++;
		for (int i = 0; i < 30; i++)
			send_beat(random_req(90));
		wait_drained();
	endtask

	// Short random bursts, each followed by a full drain of responses
	task automatic test_drain_pause();
		for (int round = 0; round < 5; round++) begin
			for (int i = 0; i < 24; i++)
				offer(random_req(50));
			wait_drained();
		end
	endtask

	// Load phases rotate so the stack is driven to full (refusals), churned and worked down by reads
	task automatic test_random_mix(input int unsigned count);
		load_phase_t phase;
		int unsigned push_pct;
		for (int unsigned i = 0; i < count; i++) begin
			phase = load_phase_t'((i / 100) % 3);
			case (phase)
				PH_FILL:  push_pct = 85;
				PH_CHURN: push_pct = 45;
				default:  push_pct = 15;
			endcase
			offer(random_req(push_pct));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_word_extremes();
		test_backpressure_hold();
		test_drain_pause();
		test_random_mix(RANDOM_ITEMS);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (stack_expected.size() != 0)
			report_mismatch("responses never returned", stack_expected.size(), '0);

		$display("%0d requests sent, %0d responses checked, %0d mismatches",
			items_sent, beats_checked, fail_count);
		$display("peak depth %0d of %0d, %0d full refusals, %0d empty reads, %0d middle deletes",
			peak_count, DEPTH_DEF, refused_pushes, empty_reads, middle_deletes);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
